FILE: rtl/core/opmsd_pkg.sv
// shared widths, register codes and types of the ordered placement block
`default_nettype none

package opmsd_pkg;

  localparam int VALUE_W   = 16;
  localparam int TOTAL_W   = 21;
  localparam int COL_W     = 6;
  localparam int CFG_W     = 6;
  localparam int CFG_IDX_W = 1;

  localparam int DEF_MAX_ROWS    = 32;
  localparam int DEF_MAX_COLUMNS = 32;

  localparam logic [CFG_IDX_W-1:0] REG_FLOWER_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_VASE_COUNT   = 1'b1;

  localparam logic KIND_TOTAL  = 1'b0;
  localparam logic KIND_COLUMN = 1'b1;

  localparam logic signed [TOTAL_W-1:0] SUM_MAX = 21'sh0FFFFF;
  localparam logic signed [TOTAL_W-1:0] SUM_MIN = 21'sh100000;

  typedef struct packed {
    logic signed [TOTAL_W-1:0] sum;
    logic                      gt;
  } unit_res_t;

endpackage

`default_nettype wire

FILE: rtl/core/opmsd_unit.sv
// shared saturating adder and signed comparator
`default_nettype none

module opmsd_unit import opmsd_pkg::*; (
  input  logic signed [TOTAL_W-1:0] a_i,
  input  logic signed [TOTAL_W-1:0] b_i,
  input  logic signed [TOTAL_W-1:0] c_i,
  output unit_res_t                 res_o
);

  logic signed [TOTAL_W:0] wide_sum;

  assign wide_sum = {a_i[TOTAL_W-1], a_i} + {b_i[TOTAL_W-1], b_i};

  always_comb begin
    if (wide_sum[TOTAL_W] != wide_sum[TOTAL_W-1]) begin
      res_o.sum = wide_sum[TOTAL_W] ? SUM_MIN : SUM_MAX;
    end else begin
      res_o.sum = wide_sum[TOTAL_W-1:0];
    end
    res_o.gt = (c_i > a_i);
  end

endmodule

`default_nettype wire

FILE: rtl/core/ordered_placement_max_score_dp.sv
// top level: sequencer, score stores and traceback of the ordered placement block
//
// Scores arrive one per command: value_i is taken at a clock edge with start_i
// high and busy_o low, in row-major order over flower_count rows and
// vase_count columns. Each value is accepted, then gets one cell update
// through the shared add/compare unit after the registered read of the
// previous-row store; busy_o stays high until that update is done.
// After the last value of the matrix the block stays busy through the cell
// update, the best-column scan (one read and one compare per column), the
// back-pointer walk (one memory read per row) and the total load, then shows
// the total and the F chosen columns, F+1 results in all, each marked by
// out_strobe_o; last_o flags the final one. When F > V a single result with
// no_solution_o set is shown instead, after the scan. Results cannot be held off.
// Config writes (cfg_we_i, cfg_idx_i, cfg_data_i) are to be made by the user
// only while busy_o is low; the block does not enforce this. Any write
// restarts the matrix at row 1, column 1.
// Reset sets both counts to 1 and the position to the first cell; the score
// stores need no clearing since each entry is written before it is read.
`default_nettype none

module ordered_placement_max_score_dp import opmsd_pkg::*; #(
  parameter int MAX_ROWS    = DEF_MAX_ROWS,
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic signed [VALUE_W-1:0] value_i,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [CFG_W-1:0]          cfg_data_i,
  output logic                      out_strobe_o,
  output logic                      kind_o,
  output logic signed [TOTAL_W-1:0] total_o,
  output logic [COL_W-1:0]          column_o,
  output logic                      no_solution_o,
  output logic                      last_o
);

  localparam int RW       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW       = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int BP_AW    = RW + CW;
  localparam int BP_DEPTH = 1 << BP_AW;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CELL,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_TRACE_INIT,
    S_TRACE_RD,
    S_TRACE_WR,
    S_OUT_TOTAL,
    S_OUT_COL
  } state_e;

  state_e                    state_q;
  logic [RW-1:0]             row_q;
  logic [CW-1:0]             col_q;
  logic [RW-1:0]             last_row_q;
  logic [CW-1:0]             last_col_q;
  logic signed [VALUE_W-1:0] value_q;
  logic signed [TOTAL_W-1:0] prefix_best_q;
  logic [COL_W-1:0]          prefix_col_q;
  logic                      prefix_ok_q;
  logic signed [TOTAL_W-1:0] best_q;
  logic [COL_W-1:0]          best_col_q;
  logic                      found_q;
  logic [RW-1:0]             tr_q;
  logic [COL_W-1:0]          tr_col_q;
  logic [RW-1:0]             out_idx_q;
  logic                      strobe_q;
  logic                      kind_q;
  logic signed [TOTAL_W-1:0] total_q;
  logic [COL_W-1:0]          column_q;
  logic                      nosol_q;
  logic                      last_q;

  // memories
  logic [TOTAL_W:0]          prev_mem [MAX_COLUMNS];
  logic [COL_W-1:0]          bp_mem   [BP_DEPTH];
  logic [COL_W-1:0]          ch_mem   [MAX_ROWS];
  logic [TOTAL_W:0]          prev_rd_q;
  logic [COL_W-1:0]          bp_rd_q;
  logic [COL_W-1:0]          ch_rd_q;

  logic signed [TOTAL_W-1:0] value_ext;
  logic signed [TOTAL_W-1:0] prev_val;
  logic                      prev_ok;
  logic signed [TOTAL_W-1:0] unit_a;
  unit_res_t                 unit_res;
  logic                      row0;
  logic signed [TOTAL_W-1:0] cur_val;
  logic                      cur_ok;
  logic                      take_prefix;
  logic                      bp_we;
  logic [BP_AW-1:0]          bp_waddr;
  logic [BP_AW-1:0]          bp_raddr;
  logic [COL_W-1:0]          bp_fix;
  logic                      ch_we;
  logic [RW-1:0]             ch_waddr;
  logic [COL_W-1:0]          ch_wdata;
  logic [RW-1:0]             ch_raddr;
  logic [RW-1:0]             cfg_last_row;
  logic [CW-1:0]             cfg_last_col;
  logic                      no_sol;

  assign busy_o        = (state_q != S_IDLE);
  assign out_strobe_o  = strobe_q;
  assign kind_o        = kind_q;
  assign total_o       = total_q;
  assign column_o      = column_q;
  assign no_solution_o = nosol_q;
  assign last_o        = last_q;

  assign value_ext = {{(TOTAL_W-VALUE_W){value_q[VALUE_W-1]}}, value_q};
  assign prev_val  = prev_rd_q[TOTAL_W-1:0];
  assign prev_ok   = prev_rd_q[TOTAL_W];
  assign row0      = (row_q == '0);
  assign no_sol    = (32'(last_row_q) > 32'(last_col_q));

  // the scan compares against the running best, the cell against the prefix
  assign unit_a = (state_q == S_SCAN_CMP) ? best_q : prefix_best_q;

  opmsd_unit u_unit (
    .a_i   (unit_a),
    .b_i   (value_ext),
    .c_i   (prev_val),
    .res_o (unit_res)
  );

  assign cur_val     = row0 ? value_ext : unit_res.sum;
  assign cur_ok      = row0 | prefix_ok_q;
  assign take_prefix = !row0 && prev_ok && (!prefix_ok_q || unit_res.gt);

  assign bp_we    = (state_q == S_CELL) && !row0 && prefix_ok_q;
  assign bp_waddr = {row_q, col_q};
  assign bp_raddr = {tr_q, CW'(tr_col_q - COL_W'(1))};
  assign bp_fix   = (bp_rd_q == '0) ? COL_W'(1) : bp_rd_q;

  always_comb begin
    ch_we    = 1'b0;
    ch_waddr = last_row_q;
    ch_wdata = best_col_q;
    if (state_q == S_TRACE_INIT) begin
      ch_we = 1'b1;
    end else if (state_q == S_TRACE_WR) begin
      ch_we    = 1'b1;
      ch_waddr = tr_q - RW'(1);
      ch_wdata = bp_fix;
    end
  end

  // prefetch the next chosen column while the current one is shown
  assign ch_raddr = (state_q == S_OUT_COL && out_idx_q != last_row_q) ?
                    out_idx_q + RW'(1) : '0;

  always_comb begin
    if (cfg_data_i == '0) begin
      cfg_last_row = '0;
    end else if (32'(cfg_data_i) > MAX_ROWS) begin
      cfg_last_row = RW'(MAX_ROWS - 1);
    end else begin
      cfg_last_row = RW'(cfg_data_i - CFG_W'(1));
    end
    if (cfg_data_i == '0) begin
      cfg_last_col = '0;
    end else if (32'(cfg_data_i) > MAX_COLUMNS) begin
      cfg_last_col = CW'(MAX_COLUMNS - 1);
    end else begin
      cfg_last_col = CW'(cfg_data_i - CFG_W'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_CELL) begin
      prev_mem[col_q] <= {cur_ok, cur_val};
    end
    prev_rd_q <= prev_mem[col_q];
  end

  always_ff @(posedge clk_i) begin
    if (bp_we) begin
      bp_mem[bp_waddr] <= prefix_col_q;
    end
    bp_rd_q <= bp_mem[bp_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (ch_we) begin
      ch_mem[ch_waddr] <= ch_wdata;
    end
    ch_rd_q <= ch_mem[ch_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      row_q         <= '0;
      col_q         <= '0;
      last_row_q    <= '0;
      last_col_q    <= '0;
      value_q       <= '0;
      prefix_best_q <= '0;
      prefix_ok_q   <= 1'b0;
      prefix_col_q  <= '0;
      best_q        <= '0;
      best_col_q    <= '0;
      found_q       <= 1'b0;
      tr_q          <= '0;
      tr_col_q      <= '0;
      out_idx_q     <= '0;
      strobe_q      <= 1'b0;
      kind_q        <= KIND_TOTAL;
      total_q       <= '0;
      column_q      <= '0;
      nosol_q       <= 1'b0;
      last_q        <= 1'b0;
    end else begin
      strobe_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            value_q <= value_i;
            state_q <= S_CELL;
          end
        end
        S_CELL: begin
          if (take_prefix) begin
            prefix_best_q <= prev_val;
            prefix_col_q  <= COL_W'(col_q) + COL_W'(1);
            prefix_ok_q   <= 1'b1;
          end
          state_q <= S_IDLE;
          if (col_q == last_col_q) begin
            col_q        <= '0;
            prefix_ok_q  <= 1'b0;
            prefix_col_q <= '0;
            if (row_q == last_row_q) begin
              row_q   <= '0;
              found_q <= 1'b0;
              state_q <= S_SCAN_RD;
            end else begin
              row_q <= row_q + RW'(1);
            end
          end else begin
            col_q <= col_q + CW'(1);
          end
        end
        S_SCAN_RD: begin
          state_q <= S_SCAN_CMP;
        end
        S_SCAN_CMP: begin
          // strict compare keeps the earliest column on ties
          if (prev_ok && (!found_q || unit_res.gt)) begin
            best_q     <= prev_val;
            best_col_q <= COL_W'(col_q) + COL_W'(1);
            found_q    <= 1'b1;
          end
          if (col_q == last_col_q) begin
            col_q   <= '0;
            state_q <= S_TRACE_INIT;
          end else begin
            col_q   <= col_q + CW'(1);
            state_q <= S_SCAN_RD;
          end
        end
        S_TRACE_INIT: begin
          if (no_sol || !found_q) begin
            strobe_q <= 1'b1;
            kind_q   <= KIND_TOTAL;
            total_q  <= '0;
            column_q <= '0;
            nosol_q  <= 1'b1;
            last_q   <= 1'b1;
            state_q  <= S_IDLE;
          end else begin
            tr_col_q <= best_col_q;
            tr_q     <= last_row_q;
            state_q  <= (last_row_q == '0) ? S_OUT_TOTAL : S_TRACE_RD;
          end
        end
        S_TRACE_RD: begin
          state_q <= S_TRACE_WR;
        end
        S_TRACE_WR: begin
          tr_col_q <= bp_fix;
          tr_q     <= tr_q - RW'(1);
          state_q  <= (tr_q == RW'(1)) ? S_OUT_TOTAL : S_TRACE_RD;
        end
        S_OUT_TOTAL: begin
          strobe_q  <= 1'b1;
          kind_q    <= KIND_TOTAL;
          total_q   <= best_q;
          column_q  <= '0;
          nosol_q   <= 1'b0;
          last_q    <= 1'b0;
          out_idx_q <= '0;
          state_q   <= S_OUT_COL;
        end
        S_OUT_COL: begin
          strobe_q <= 1'b1;
          kind_q   <= KIND_COLUMN;
          total_q  <= '0;
          column_q <= ch_rd_q;
          nosol_q  <= 1'b0;
          last_q   <= (out_idx_q == last_row_q);
          if (out_idx_q == last_row_q) begin
            state_q <= S_IDLE;
          end else begin
            out_idx_q <= out_idx_q + RW'(1);
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase

      // any register write restarts the matrix
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_FLOWER_COUNT: last_row_q <= cfg_last_row;
          REG_VASE_COUNT:   last_col_q <= cfg_last_col;
          default:          last_row_q <= last_row_q;
        endcase
        row_q        <= '0;
        col_q        <= '0;
        prefix_ok_q  <= 1'b0;
        prefix_col_q <= '0;
      end
    end
  end

`ifndef SYNTHESIS
  a_strobe_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_strobe_o |-> $past(busy_o))
    else $error("result strobe without a preceding busy cycle");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_strobe_o && last_o |=> !out_strobe_o)
    else $error("result transfer after the last one of a run");

  a_nosol_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_strobe_o && no_solution_o |-> last_o && (kind_o == KIND_TOTAL))
    else $error("no-solution result is not a lone total");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("accepted value did not start a cell update");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/tb_ordered_placement_max_score_dp.sv
// self-checking testbench for the ordered placement max score block with a matrix-level predictor
`timescale 1ns / 1ps

module tb_ordered_placement_max_score_dp;
  import opmsd_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 4;
  localparam int TAIL_CYCLES  = 200;
  localparam int RANDOM_ITEMS = 360;

  typedef struct packed {
    logic               kind;
    logic [TOTAL_W-1:0] total;
    logic [COL_W-1:0]   column;
    logic               no_sol;
    logic               last;
  } placement_t;

  typedef enum int {MIX_FULL, MIX_TIES, MIX_EXTREME, MIX_NEGATIVE} score_mix_e;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      start_i = 1'b0;
  logic signed [VALUE_W-1:0] value_i = '0;
  logic                      cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_idx_i = '0;
  logic [CFG_W-1:0]          cfg_data_i = '0;
  logic                      busy_o;
  logic                      out_strobe_o;
  logic                      kind_o;
  logic signed [TOTAL_W-1:0] total_o;
  logic [COL_W-1:0]          column_o;
  logic                      no_solution_o;
  logic                      last_o;

  ordered_placement_max_score_dp uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .value_i       (value_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .out_strobe_o  (out_strobe_o),
    .kind_o        (kind_o),
    .total_o       (total_o),
    .column_o      (column_o),
    .no_solution_o (no_solution_o),
    .last_o        (last_o)
  );

  always #5 clk_i = ~clk_i;

  logic signed [VALUE_W-1:0] pending_scores [$];
  placement_t                pending_placements [$];
  int  queued_count = 0;
  int  accepted_count = 0;
  int  mismatch_count = 0;
  int  cycle_count = 0;
  int  gap_pct = 35;
  logic took = 1'b0;

  // predictor state
  logic [CFG_W-1:0]          flower_cfg;
  logic [CFG_W-1:0]          vase_cfg;
  logic signed [TOTAL_W-1:0] prev_best [DEF_MAX_COLUMNS];
  logic                      prev_reach [DEF_MAX_COLUMNS];
  logic [COL_W-1:0]          back_col [DEF_MAX_ROWS][DEF_MAX_COLUMNS];
  int unsigned               row_pos;
  int unsigned               col_pos;
  logic signed [TOTAL_W-1:0] run_best;
  logic                      run_ok;
  logic [COL_W-1:0]          run_col;

  function automatic int unsigned eff_count(input logic [CFG_W-1:0] raw, input int unsigned hi);
    if (raw == '0) return 1;
    return (raw > hi) ? hi : int'(raw);
  endfunction

  task automatic restart_matrix();
    row_pos = 0;
    col_pos = 0;
    run_best = '0;
    run_ok = 1'b0;
    run_col = '0;
  endtask

  task automatic queue_placement(input int unsigned rows, input int unsigned cols);
    int unsigned               pick [DEF_MAX_ROWS];
    int unsigned               best_c;
    logic signed [TOTAL_W-1:0] best;
    logic                      found;
    placement_t                res;
    found = 1'b0;
    best = '0;
    best_c = 0;
    if (rows <= cols) begin
      for (int c = 0; c < int'(cols); c++) begin
        // strict compare keeps the earliest column on ties
        if (prev_reach[c] && (!found || prev_best[c] > best)) begin
          best = prev_best[c];
          best_c = c + 1;
          found = 1'b1;
        end
      end
    end
    if (!found) begin
      res = '{kind: KIND_TOTAL, total: '0, column: '0, no_sol: 1'b1, last: 1'b1};
      pending_placements.push_back(res);
    end else begin
      pick[rows-1] = best_c;
      for (int r = int'(rows) - 1; r >= 1; r--) begin
        pick[r-1] = back_col[r][pick[r]-1];
        if (pick[r-1] == 0) pick[r-1] = 1;
      end
      res = '{kind: KIND_TOTAL, total: best, column: '0, no_sol: 1'b0, last: 1'b0};
      pending_placements.push_back(res);
      for (int r = 0; r < int'(rows); r++) begin
        res = '{kind: KIND_COLUMN, total: '0, column: COL_W'(pick[r]), no_sol: 1'b0,
                last: (r == int'(rows) - 1)};
        pending_placements.push_back(res);
      end
    end
  endtask

  task automatic score_cell(input logic signed [VALUE_W-1:0] v);
    int unsigned               rows;
    int unsigned               cols;
    int                        sum;
    logic signed [TOTAL_W-1:0] cell_val;
    logic                      cell_ok;
    rows = eff_count(flower_cfg, DEF_MAX_ROWS);
    cols = eff_count(vase_cfg, DEF_MAX_COLUMNS);
    cell_val = '0;
    cell_ok = 1'b0;
    if (row_pos >= rows || col_pos >= cols) restart_matrix();
    if (row_pos == 0) begin
      cell_val = v;
      cell_ok = 1'b1;
    end else begin
      if (run_ok) begin
        sum = int'(run_best) + int'(v);
        if (sum > int'(SUM_MAX)) sum = int'(SUM_MAX);
        if (sum < int'(SUM_MIN)) sum = int'(SUM_MIN);
        cell_val = sum[TOTAL_W-1:0];
        cell_ok = 1'b1;
        back_col[row_pos][col_pos] = run_col;
      end
      // prefix max over the previous row, extended after this cell used it
      if (prev_reach[col_pos] && (!run_ok || prev_best[col_pos] > run_best)) begin
        run_best = prev_best[col_pos];
        run_col = COL_W'(col_pos + 1);
        run_ok = 1'b1;
      end
    end
    prev_best[col_pos] = cell_val;
    prev_reach[col_pos] = cell_ok;
    col_pos++;
    if (col_pos >= cols) begin
      col_pos = 0;
      run_best = '0;
      run_ok = 1'b0;
      run_col = '0;
      row_pos++;
      if (row_pos >= rows) begin
        row_pos = 0;
        queue_placement(rows, cols);
      end
    end
  endtask

  // accepts transfers, updates the predictor and checks results
  always @(posedge clk_i) begin
    placement_t want;
    cycle_count++;
    if (!rst_ni) begin
      flower_cfg = 1;
      vase_cfg = 1;
      for (int c = 0; c < DEF_MAX_COLUMNS; c++) prev_reach[c] = 1'b0;
      restart_matrix();
      took <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_FLOWER_COUNT) flower_cfg = cfg_data_i;
        else if (cfg_idx_i == REG_VASE_COUNT) vase_cfg = cfg_data_i;
        restart_matrix();
      end
      if (start_i && !busy_o) begin
        score_cell(value_i);
        accepted_count++;
        took <= 1'b1;
      end else begin
        took <= 1'b0;
      end
      if (out_strobe_o) begin
        if (pending_placements.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result: kind %0d total %0d column %0d nosol %0d last %0d",
                     kind_o, total_o, column_o, no_solution_o, last_o);
        end else begin
          want = pending_placements.pop_front();
          if (kind_o !== want.kind || total_o !== want.total || column_o !== want.column ||
              no_solution_o !== want.no_sol || last_o !== want.last) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: expected kind %0d total %0d column %0d nosol %0d last %0d,",
                       want.kind, $signed(want.total), want.column, want.no_sol, want.last,
                       " got kind %0d total %0d column %0d nosol %0d last %0d",
                       kind_o, total_o, column_o, no_solution_o, last_o);
          end
        end
      end
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // start stays high until the transfer, then the next score follows or a gap
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else if (!start_i || took) begin
      if (pending_scores.size() != 0 && $urandom_range(99) >= gap_pct) begin
        start_i <= 1'b1;
        value_i <= pending_scores.pop_front();
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  function automatic logic [VALUE_W-1:0] draw_score(input score_mix_e mix);
    case (mix)
      MIX_FULL: return VALUE_W'($urandom_range(0, 65535));
      MIX_TIES: return VALUE_W'($urandom_range(0, 3));
      MIX_EXTREME: begin
        case ($urandom_range(3))
          0: return 16'h8000;
          1: return 16'h7fff;
          2: return '0;
          default: return '1;
        endcase
      end
      default: return VALUE_W'(-int'($urandom_range(0, 300)));
    endcase
  endfunction

  task automatic queue_scores(input int unsigned n, input score_mix_e mix);
    repeat (n) begin
      pending_scores.push_back(draw_score(mix));
      queued_count++;
    end
  endtask

  task automatic queue_value(input logic signed [VALUE_W-1:0] v);
    pending_scores.push_back(v);
    queued_count++;
  endtask

  // every score taken, every result seen and the block idle again
  task automatic wait_idle();
    while (accepted_count != queued_count || pending_placements.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    while (busy_o) @(negedge clk_i);
  endtask

  task automatic write_count(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data[CFG_W-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_session(input int unsigned f, input int unsigned v, input int unsigned mats);
    int unsigned cells;
    wait_idle();
    if (queued_count < 125) gap_pct = 35;
    else if (queued_count < 250) gap_pct = 58;
    else gap_pct = 0;
    if ($urandom_range(1) == 1) begin
      write_count(REG_FLOWER_COUNT, f);
      write_count(REG_VASE_COUNT, v);
    end else begin
      write_count(REG_VASE_COUNT, v);
      write_count(REG_FLOWER_COUNT, f);
    end
    cells = eff_count(f[CFG_W-1:0], DEF_MAX_ROWS) * eff_count(v[CFG_W-1:0], DEF_MAX_COLUMNS);
    repeat (mats) queue_scores(cells, score_mix_e'($urandom_range(3)));
    // a cut-off matrix, restarted by the next register write
    if (cells > 1 && $urandom_range(5) == 0)
      queue_scores($urandom_range(1, cells - 1), score_mix_e'($urandom_range(3)));
  endtask

  initial begin
    int unsigned f;
    int unsigned v;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // counts at reset: one row, one column
    queue_value(16'sh7fff);
    wait_idle();
    write_count(REG_FLOWER_COUNT, 2);
    queue_value(-16'sh8000);
    queue_value(16'sh0000);
    wait_idle();
    // zero counts act as one
    write_count(REG_FLOWER_COUNT, 0);
    write_count(REG_VASE_COUNT, 0);
    queue_value(-16'sh8000);
    wait_idle();
    // all-equal scores, earliest column wins
    write_count(REG_FLOWER_COUNT, 2);
    write_count(REG_VASE_COUNT, 3);
    repeat (6) queue_value(16'sd5);
    wait_idle();
    // square matrix: lower cells unreachable, extremes in all but one of the other cells
    write_count(REG_FLOWER_COUNT, 3);
    queue_value(16'sh7fff);  queue_value(-16'sh8000); queue_value(16'sh7fff);
    queue_value(-16'sh8000); queue_value(-16'sd1);    queue_value(16'sh7fff);
    queue_value(16'sd1);     queue_value(16'sh7fff);  queue_value(-16'sh8000);
    // partial matrix, the next write restarts it
    queue_value(16'sd1); queue_value(16'sd2); queue_value(16'sd3); queue_value(16'sd4);

    // oversized and undersized counts
    run_session(63, 1, 1);
    run_session(1, 63, 1);
    run_session(32, 2, 1);
    run_session(2, 32, 1);
    run_session(0, 5, 1);
    run_session(5, 0, 1);

    while (queued_count < RANDOM_ITEMS) begin
      f = $urandom_range(1, 5);
      v = $urandom_range(1, 7);
      run_session(f, v, $urandom_range(1, 3));
    end

    while (accepted_count != queued_count || pending_placements.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_placements.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/opmsd_pkg.sv
rtl/core/opmsd_unit.sv
rtl/core/ordered_placement_max_score_dp.sv
tb/sv/tb_ordered_placement_max_score_dp.sv
